// ===== sv/ppu_sar_pkg.sv =====
package ppu_sar_pkg;

   localparam int unsigned ADDR_WIDTH = 15;

   localparam logic [3:0] OP_CTRL_WRITE   = 4'd0;
   localparam logic [3:0] OP_STATUS_READ  = 4'd1;
   localparam logic [3:0] OP_SCROLL_WRITE = 4'd2;
   localparam logic [3:0] OP_ADDR_WRITE   = 4'd3;
   localparam logic [3:0] OP_DATA_ACCESS  = 4'd4;
   localparam logic [3:0] OP_COARSE_X     = 4'd5;
   localparam logic [3:0] OP_Y_STEP       = 4'd6;
   localparam logic [3:0] OP_HCOPY        = 4'd7;
   localparam logic [3:0] OP_VCOPY        = 4'd8;
   localparam logic [3:0] OP_TICK         = 4'd9;

   localparam logic [ADDR_WIDTH-1:0] CTRL_KEEP_MASK    = 15'h73FF;
   localparam logic [ADDR_WIDTH-1:0] SCROLL1_KEEP_MASK = 15'h7FE0;
   localparam logic [ADDR_WIDTH-1:0] SCROLL2_KEEP_MASK = 15'h0C1F;
   localparam logic [ADDR_WIDTH-1:0] ADDR2_KEEP_MASK   = 15'h7F00;
   localparam logic [ADDR_WIDTH-1:0] ROW_29_CODE       = 15'h03A0;
   localparam logic [ADDR_WIDTH-1:0] COARSE_Y_MASK     = 15'h03E0;
   localparam logic [ADDR_WIDTH-1:0] VERT_MASK         = 15'h7BE0;
   localparam logic [ADDR_WIDTH-1:0] HORIZ_MASK        = 15'h041F;
   localparam logic [ADDR_WIDTH-1:0] FINE_Y_MAX        = 15'h7000;
   localparam logic [ADDR_WIDTH-1:0] FINE_Y_STEP       = 15'h1000;
   localparam logic [ADDR_WIDTH-1:0] ROW_STEP          = 15'h0020;
   localparam logic [ADDR_WIDTH-1:0] ROW_29_FLIP       = 15'h0BA0;
   localparam logic [ADDR_WIDTH-1:0] FINE_Y_CLEAR      = 15'h0FFF;
   localparam logic [2:0]            COPY_DELAY_LOAD   = 3'd4;
   localparam int unsigned           STEP_32_BIT       = 2;

   typedef struct packed {
      logic [3:0] opcode;
      logic [7:0] bus_byte;
      logic       rendering_active;
      logic [8:0] dot;
   } req_item_type;

   typedef struct packed {
      logic [ADDR_WIDTH-1:0] current_address;
      logic [ADDR_WIDTH-1:0] temp_address;
      logic [2:0]            fine_scroll_x;
      logic                  second_write;
   } rsp_item_type;

   typedef struct packed {
      logic [ADDR_WIDTH-1:0] current_addr;
      logic [ADDR_WIDTH-1:0] temp_addr;
      logic [2:0]            fine_x;
      logic                  write_toggle;
      logic [2:0]            copy_delay;
      logic                  step_by_32;
   } state_type;

   function automatic logic [ADDR_WIDTH-1:0] coarse_x_step(input logic [ADDR_WIDTH-1:0] a);
      logic [ADDR_WIDTH-1:0] r;
      if (a[4:0] != 5'h1F) begin
         r = a + ADDR_WIDTH'(1);
      end else begin
         r = a ^ HORIZ_MASK;
      end
      return r;
   endfunction

   function automatic logic [ADDR_WIDTH-1:0] y_step(input logic [ADDR_WIDTH-1:0] a);
      logic [ADDR_WIDTH-1:0] r;
      if (a < FINE_Y_MAX) begin
         r = a + FINE_Y_STEP;
      end else begin
         r = a & FINE_Y_CLEAR;
         if ((r & COARSE_Y_MASK) == ROW_29_CODE) begin
            r = r ^ ROW_29_FLIP;
         end else if ((r & COARSE_Y_MASK) == COARSE_Y_MASK) begin
            r = r & SCROLL2_KEEP_MASK;
         end else begin
            r = r + ROW_STEP;
         end
      end
      return r;
   endfunction

endpackage

// ===== sv/ppu_sar_update.sv =====
module ppu_sar_update (
   input  ppu_sar_pkg::req_item_type item,
   input  ppu_sar_pkg::state_type    state,
   output ppu_sar_pkg::state_type    state_next
);
   import ppu_sar_pkg::*;

   logic [ADDR_WIDTH-1:0] byte_ext;
   logic [ADDR_WIDTH-1:0] render_y;
   logic                  dot_x_window;
   logic [2:0]            delay_shifted;

   assign byte_ext      = ADDR_WIDTH'(item.bus_byte);
   assign render_y      = (item.dot != 9'd256) ? y_step(state.current_addr) : state.current_addr;
   assign dot_x_window  = ((item.dot >= 9'd1 && item.dot <= 9'd256) || item.dot >= 9'd321)
                          && (item.dot[2:0] != 3'd0);
   assign delay_shifted = state.copy_delay >> 1;

   always_comb begin
      state_next = state;
      case (item.opcode)
         OP_CTRL_WRITE: begin
            state_next.step_by_32 = item.bus_byte[STEP_32_BIT];
            state_next.temp_addr  = (state.temp_addr & CTRL_KEEP_MASK)
                                    | {3'd0, item.bus_byte[1:0], 10'd0};
         end
         OP_STATUS_READ: begin
            state_next.write_toggle = 1'b0;
         end
         OP_SCROLL_WRITE: begin
            if (!state.write_toggle) begin
               state_next.temp_addr = (state.temp_addr & SCROLL1_KEEP_MASK) | (byte_ext >> 3);
               state_next.fine_x    = item.bus_byte[2:0];
            end else begin
               state_next.temp_addr = (state.temp_addr & SCROLL2_KEEP_MASK)
                                      | {item.bus_byte[2:0], 12'd0}
                                      | {5'd0, item.bus_byte[7:3], 5'd0};
            end
            state_next.write_toggle = !state.write_toggle;
         end
         OP_ADDR_WRITE: begin
            if (!state.write_toggle) begin
               state_next.temp_addr = {1'b0, item.bus_byte[5:0], state.temp_addr[7:0]};
            end else begin
               state_next.temp_addr  = (state.temp_addr & ADDR2_KEEP_MASK) | byte_ext;
               state_next.copy_delay = COPY_DELAY_LOAD;
            end
            state_next.write_toggle = !state.write_toggle;
         end
         OP_DATA_ACCESS: begin
            if (!item.rendering_active) begin
               state_next.current_addr = state.current_addr
                                         + (state.step_by_32 ? ROW_STEP : ADDR_WIDTH'(1));
            end else if (dot_x_window) begin
               state_next.current_addr = coarse_x_step(render_y);
            end else begin
               state_next.current_addr = render_y;
            end
         end
         OP_COARSE_X: begin
            state_next.current_addr = coarse_x_step(state.current_addr);
         end
         OP_Y_STEP: begin
            state_next.current_addr = y_step(state.current_addr);
         end
         OP_HCOPY: begin
            state_next.current_addr = (state.current_addr & VERT_MASK)
                                      | (state.temp_addr & HORIZ_MASK);
         end
         OP_VCOPY: begin
            state_next.current_addr = (state.current_addr & HORIZ_MASK)
                                      | (state.temp_addr & VERT_MASK);
         end
         OP_TICK: begin
            state_next.copy_delay = delay_shifted;
            if (delay_shifted[0]) begin
               state_next.current_addr = state.temp_addr;
            end
         end
         default: begin
            state_next = state;
         end
      endcase
   end

endmodule

// ===== sv/ppu_scroll_address_registers.sv =====
// Scroll and address registers of the picture unit: current and temporary
// 15-bit video addresses, fine X scroll, the shared write toggle, the delayed
// copy started by the second address write and the step-by-32 bit. Each req
// item carries one opcode and gives exactly one rsp item with the register
// values after it. An item waits in the input register, is applied
// to the state by a single pass of bit-field logic and lands in the result
// register; one item is taken every cycle while req_stall is low, and
// req_stall rises only while both registers are full and rsp_stall is high.
// No clearing pass is needed after reset.
module ppu_scroll_address_registers (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  ppu_sar_pkg::req_item_type req_item,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output ppu_sar_pkg::rsp_item_type rsp_item
);
   import ppu_sar_pkg::*;

   logic         in_valid_ff;
   logic         in_valid_in;
   req_item_type in_item_ff;
   logic         out_valid_ff;
   logic         out_valid_in;
   rsp_item_type out_item_ff;
   state_type    state_ff;
   state_type    state_in;
   logic         advance;
   logic         take_req;

   assign advance  = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign take_req = req_valid && !req_stall;

   assign in_valid_in  = take_req || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && rsp_stall);

   ppu_sar_update u_update (
      .item       (in_item_ff),
      .state      (state_ff),
      .state_next (state_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff     <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (advance) begin
            state_ff <= state_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take_req) begin
         in_item_ff <= req_item;
      end
      if (advance) begin
         out_item_ff.current_address <= state_in.current_addr;
         out_item_ff.temp_address    <= state_in.temp_addr;
         out_item_ff.fine_scroll_x   <= state_in.fine_x;
         out_item_ff.second_write    <= state_in.write_toggle;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_item  = out_item_ff;

   assert property (@(posedge clock) reset |=> !rsp_valid && !in_valid_ff)
      else $error("pipeline not empty after reset");

   assert property (@(posedge clock) disable iff (reset) advance |=> rsp_valid)
      else $error("applied item did not reach the result register");

   assert property (@(posedge clock) disable iff (reset) !advance |=> $stable(state_ff))
      else $error("state changed without an item");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_item.current_address == state_ff.current_addr
                 && rsp_item.temp_address == state_ff.temp_addr
                 && rsp_item.second_write == state_ff.write_toggle)
      else $error("result register out of step with state");

endmodule
